[hw/rtl/ece_pkg.sv]
// ----------------------------------------------------------------------------
// Easing curve evaluator package
// Shared types, curve selector codes and the cosine table generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ece_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COS_DEPTH_DEF = 256;

	// pi/2 in Q30.
	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	localparam logic [1:0] OP_LINEAR     = 2'd0;
	localparam logic [1:0] OP_COSINE     = 2'd1;
	localparam logic [1:0] OP_SPRING     = 2'd2;
	localparam logic [1:0] OP_LINEAR_ALT = 2'd3;

	typedef struct packed {
		logic       valid;
		logic [1:0] op;
	} ctl_t;

	// Cosine in Q30 by a 12-term Taylor sum with truncating products.
	// Each term divides the previous one by (2n - 1) * 2n.
	function automatic longint cos_q30(longint x);
		longint unsigned ux;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		ux   = longint'(x);
		x2   = (ux * ux) >> 30;
		term = 64'd1 << 30;
		sum  = 64'sd1 << 30;
		term = ((term * x2) >> 30) / 64'd2;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd12;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd30;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd56;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd90;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd132;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd182;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd240;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd306;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd380;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd462;
		sum  = sum - longint'(term);
		if (sum < 0)
			sum = 0;
		if (sum > (64'sd1 << 30))
			sum = 64'sd1 << 30;
		return sum;
	endfunction

	// Table entry rounded half up from Q30 to the given fraction width.
	function automatic longint cos_entry(longint x, int frac);
		longint c;
		c = cos_q30(x);
		return (c + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
	endfunction

endpackage

`default_nettype wire

[hw/rtl/easing_curve_evaluator.sv]
// ----------------------------------------------------------------------------
// Easing curve evaluator
// Progress factor of a time within a window, eased by a selectable curve.
// ----------------------------------------------------------------------------
// Channel  Direction  Signals                                    Beat
// in       input      start, busy, op, now_time,                 start && !busy
//                     window_start, window_end
// out      output     done, eased_value                          done
//
// One beat enters every cycle; busy never rises. Each result is accepted in a
// single cycle with done high. The pipeline is two prep stages, the divider's
// entry stage and one stage per quotient bit, five easing stages and the
// output register. Reset clears only the control words (valid and op) and
// done; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module easing_curve_evaluator
	import ece_pkg::*;
#(
	parameter int FRAC_BITS       = FRAC_BITS_DEF,
	parameter int COS_TABLE_DEPTH = COS_DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic        [1:0]          op,
	input  wire logic signed [31:0]         now_time,
	input  wire logic signed [31:0]         window_start,
	input  wire logic signed [31:0]         window_end,
	output logic                            done,
	output logic signed      [FRAC_BITS+1:0] eased_value
);

	localparam int LATENCY = FRAC_BITS + 9;

	ctl_t               ctl_s1, ctl_s2, div_ctl;
	logic signed [32:0] num_s1, den_s1;
	logic               zero_s2;
	logic [32:0]        un_s2, ud_s2;
	logic [FRAC_BITS:0] factor;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= '{valid: start && !busy, op: op};
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		num_s1  <= 33'(now_time) - 33'(window_start);
		den_s1  <= 33'(window_end) - 33'(window_start);
		// Opposite signs mean a negative ratio, which clamps to zero.
		zero_s2 <= (num_s1 == '0) || (den_s1 == '0) || (num_s1[32] != den_s1[32]);
		un_s2   <= num_s1[32] ? 33'(-num_s1) : 33'(num_s1);
		ud_s2   <= den_s1[32] ? 33'(-den_s1) : 33'(den_s1);
	end

	ece_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (ctl_s2),
		.in_zero (zero_s2),
		.in_num  (un_s2),
		.in_den  (ud_s2),
		.out_ctl (div_ctl),
		.factor  (factor)
	);

	ece_ease #(
		.FRAC_BITS       (FRAC_BITS),
		.COS_TABLE_DEPTH (COS_TABLE_DEPTH)
	) u_ease (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ctl      (div_ctl),
		.factor      (factor),
		.done        (done),
		.eased_value (eased_value)
	);

	a_done_follows_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a matching input beat");

	a_factor_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.valid |-> (factor <= ((FRAC_BITS + 1)'(1) << FRAC_BITS)))
		else $error("progress factor above one");

	a_linear_range: assert property (@(posedge clk) disable iff (!arst_n)
		(div_ctl.valid && (div_ctl.op == OP_LINEAR || div_ctl.op == OP_LINEAR_ALT))
		|-> ##6 (done && !eased_value[FRAC_BITS+1]))
		else $error("linear result lost or negative");

endmodule

`default_nettype wire

[hw/rtl/ece_div.sv]
// ----------------------------------------------------------------------------
// Progress divider
// Restoring divider, one quotient bit per stage, saturating the ratio to one.
// ----------------------------------------------------------------------------
`default_nettype none

module ece_div
	import ece_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ctl_t                 in_ctl,
	input  wire logic                 in_zero,
	input  wire logic [32:0]          in_num,
	input  wire logic [32:0]          in_den,
	output ctl_t                      out_ctl,
	output logic      [FRAC_BITS:0]   factor
);

	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

	ctl_t                 ctl_sd  [FRAC_BITS + 1];
	logic                 zero_sd [FRAC_BITS + 1];
	logic                 one_sd  [FRAC_BITS + 1];
	logic [32:0]          rem_sd  [FRAC_BITS + 1];
	logic [32:0]          den_sd  [FRAC_BITS + 1];
	logic [FRAC_BITS-1:0] quo_sd  [FRAC_BITS + 1];

	// Entry stage: a numerator at least the denominator saturates to one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sd[0] <= '0;
		end else begin
			ctl_sd[0] <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		zero_sd[0] <= in_zero;
		one_sd[0]  <= (in_num >= in_den);
		rem_sd[0]  <= in_num;
		den_sd[0]  <= in_den;
		quo_sd[0]  <= '0;
	end

	for (genvar i = 1; i <= FRAC_BITS; i++) begin : g_bit
		logic [33:0] rem2;
		logic        ge;

		assign rem2 = {rem_sd[i-1], 1'b0};
		assign ge   = (rem2 >= {1'b0, den_sd[i-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_sd[i] <= '0;
			end else begin
				ctl_sd[i] <= ctl_sd[i-1];
			end
		end

		always_ff @(posedge clk) begin
			zero_sd[i] <= zero_sd[i-1];
			one_sd[i]  <= one_sd[i-1];
			den_sd[i]  <= den_sd[i-1];
			rem_sd[i]  <= ge ? 33'(rem2 - {1'b0, den_sd[i-1]}) : rem2[32:0];
			quo_sd[i]  <= {quo_sd[i-1][FRAC_BITS-2:0], ge};
		end
	end

	assign out_ctl = ctl_sd[FRAC_BITS];

	always_comb begin
		if (zero_sd[FRAC_BITS])
			factor = '0;
		else if (one_sd[FRAC_BITS])
			factor = ONE;
		else
			factor = {1'b0, quo_sd[FRAC_BITS]};
	end

endmodule

`default_nettype wire

[hw/rtl/ece_ease.sv]
// ----------------------------------------------------------------------------
// Easing stages
// Cosine table lookup and quintic spring polynomial, then curve selection.
// ----------------------------------------------------------------------------
`default_nettype none

module ece_ease
	import ece_pkg::*;
#(
	parameter int FRAC_BITS       = FRAC_BITS_DEF,
	parameter int COS_TABLE_DEPTH = COS_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ctl_t                        in_ctl,
	input  wire logic        [FRAC_BITS:0]   factor,
	output logic                             done,
	output logic signed      [FRAC_BITS+1:0] eased_value
);

	localparam int D   = COS_TABLE_DEPTH;
	localparam int CW  = FRAC_BITS + 1;
	localparam int PW  = $clog2(2 * D + 1);
	localparam int IW  = $clog2(D + 1);
	localparam int MW  = FRAC_BITS + PW + 1;
	localparam int W   = FRAC_BITS + 9;
	localparam int OW  = FRAC_BITS + 2;

	localparam logic [MW-1:0] TWO_D_M  = MW'(2 * D);
	localparam logic [MW-1:0] HALF_M   = MW'(1) << (FRAC_BITS - 1);
	localparam logic [PW-1:0] TWO_D_P  = PW'(2 * D);
	localparam logic [PW-1:0] D_P      = PW'(D);

	localparam logic signed [W-1:0]  K33  = W'(33);
	localparam logic signed [W-1:0]  K106 = W'(106) <<< FRAC_BITS;
	localparam logic signed [W-1:0]  K126 = W'(126) <<< FRAC_BITS;
	localparam logic signed [W-1:0]  K67  = W'(67) <<< FRAC_BITS;
	localparam logic signed [W-1:0]  K15  = W'(15) <<< FRAC_BITS;
	localparam logic signed [W-1:0]  SAT_HI = (W'(2) <<< FRAC_BITS) - W'(1);
	localparam logic signed [W-1:0]  SAT_LO = -(W'(2) <<< FRAC_BITS);
	localparam logic signed [OW:0]   ONE_S  = (OW + 1)'(1) <<< FRAC_BITS;

	logic [CW-1:0] cos_rom [D + 1];

	for (genvar k = 0; k <= D; k++) begin : g_rom
		localparam longint X = (longint'(k) * HALF_PI_Q30) / COS_TABLE_DEPTH;
		assign cos_rom[k] = CW'(cos_entry(X, FRAC_BITS));
	end

	ctl_t                   ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [FRAC_BITS:0]     f_s1, f_s2, f_s3, f_s4, f_s5;
	logic [IW-1:0]          idx_s1;
	logic                   neg_s1, neg_s2;
	logic [CW-1:0]          c_s2;
	logic [CW-1:0]          cr_s3, cr_s4, cr_s5;
	logic signed [W-1:0]    h_s1, h_s2, h_s3, h_s4, h_s5;

	// Half-wave index and folding into the quarter-wave table.
	logic [MW-1:0]          p_full;
	logic [PW-1:0]          p_cl;
	logic signed [W-1:0]    f_w;

	assign p_full = ((MW'(factor) * TWO_D_M) + HALF_M) >> FRAC_BITS;
	assign p_cl   = (p_full > MW'(2 * D)) ? TWO_D_P : p_full[PW-1:0];
	assign f_w    = W'(factor);

	// Floored products: an arithmetic shift of the signed product.
	function automatic logic signed [W-1:0] mul_floor(logic signed [W-1:0] a,
		logic [FRAC_BITS:0] f);
		logic signed [W+FRAC_BITS+1:0] prod;
		prod = a * $signed({1'b0, f});
		return W'(prod >>> FRAC_BITS);
	endfunction

	logic signed [OW:0]     c_signed;
	logic signed [OW:0]     c_diff;

	assign c_signed = neg_s2 ? -$signed((OW + 1)'(c_s2)) : $signed((OW + 1)'(c_s2));
	assign c_diff   = (ONE_S - c_signed) >>> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			done   <= 1'b0;
		end else begin
			ctl_s1 <= in_ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			done   <= ctl_s5.valid;
		end
	end

	always_ff @(posedge clk) begin
		f_s1   <= factor;
		idx_s1 <= (p_cl <= D_P) ? IW'(p_cl) : IW'(TWO_D_P - p_cl);
		neg_s1 <= (p_cl > D_P);
		h_s1   <= K33 * f_w - K106;

		f_s2   <= f_s1;
		c_s2   <= cos_rom[idx_s1];
		neg_s2 <= neg_s1;
		h_s2   <= mul_floor(h_s1, f_s1) + K126;

		f_s3   <= f_s2;
		cr_s3  <= CW'(c_diff);
		h_s3   <= mul_floor(h_s2, f_s2) - K67;

		f_s4   <= f_s3;
		cr_s4  <= cr_s3;
		h_s4   <= mul_floor(h_s3, f_s3) + K15;

		f_s5   <= f_s4;
		cr_s5  <= cr_s4;
		h_s5   <= mul_floor(h_s4, f_s4);

		case (ctl_s5.op)
			OP_COSINE: eased_value <= $signed(OW'(cr_s5));
			OP_SPRING: begin
				if (h_s5 > SAT_HI)
					eased_value <= OW'(SAT_HI);
				else if (h_s5 < SAT_LO)
					eased_value <= OW'(SAT_LO);
				else
					eased_value <= OW'(h_s5);
			end
			default:   eased_value <= $signed(OW'(f_s5));
		endcase
	end

endmodule

`default_nettype wire
